>>> rtl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the token check with lockout block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

  localparam int unsigned TokenBytes = 16;
  localparam int unsigned TokenBits  = TokenBytes * 8;
  localparam int unsigned LenW       = 5;
  localparam int unsigned CountW     = 8;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [LenW-1:0]   TokenBytesLen = LenW'(TokenBytes);
  localparam logic [CountW-1:0] MaxWrongRst   = 8'd5;
  localparam logic [TimeW-1:0]  LockSecRst    = 16'd300;
  localparam logic [TimeW-1:0]  TimeMax       = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_ATTEMPT = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOKEN_LOW  = 3'd0,
    CFG_TOKEN_HIGH = 3'd1,
    CFG_TOKEN_LEN  = 3'd2,
    CFG_MAX_WRONG  = 3'd3,
    CFG_LOCK_SEC   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    kind_e                kind;
    logic                 present;
    logic [LenW-1:0]      length;
    logic                 overlong;
    logic [TokenBits-1:0] bytes;
  } item_t;

  typedef struct packed {
    logic [TokenBits-1:0] token;
    logic [LenW-1:0]      token_len;
    logic [CountW-1:0]    max_wrong;
    logic [TimeW-1:0]     lock_sec;
  } cfg_t;

  typedef struct packed {
    logic              granted;
    logic              locked;
    logic [TimeW-1:0]  remaining;
    logic [CountW-1:0] failures;
    logic              token_required;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/token_check_with_lockout_core.sv
// ----------------------------------------------------------------------------
// token_check_with_lockout_core
// Token check with failed-attempt lockout: top level.
// ----------------------------------------------------------------------------
// Each item (tick, token attempt or clear) gives exactly one result item.
// The block takes one item per clock cycle while the output does not stall;
// each item passes the input register, then the byte compare and the counter
// and timer update into the result register. The configuration port is
// always ready; writing any token register clears the failure count and the
// lock timer.
`default_nettype none

module token_check_with_lockout_core import tcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Input item channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic                 attempt_present_i,
  input  logic [LenW-1:0]      attempt_length_i,
  input  logic                 attempt_overlong_i,
  input  logic [63:0]          attempt_bytes_low_i,
  input  logic [63:0]          attempt_bytes_high_i,
  // Result item channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 granted_o,
  output logic                 locked_o,
  output logic [TimeW-1:0]     remaining_lock_o,
  output logic [CountW-1:0]    failure_count_o,
  output logic                 token_required_o
);

  cfg_t    cfg_q;
  logic    cfg_we;
  logic    state_clr;
  item_t   item_q;
  logic    in_vld_q;
  logic    out_vld_q;
  result_t res_q;
  result_t res_d;
  logic    match;
  logic    fire;
  logic    in_take;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.token     <= '0;
      cfg_q.token_len <= '0;
      cfg_q.max_wrong <= MaxWrongRst;
      cfg_q.lock_sec  <= LockSecRst;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TOKEN_LOW:  cfg_q.token[63:0]   <= cfg_data_i;
        CFG_TOKEN_HIGH: cfg_q.token[127:64] <= cfg_data_i;
        CFG_TOKEN_LEN:  cfg_q.token_len     <= cfg_data_i[LenW-1:0];
        CFG_MAX_WRONG:  cfg_q.max_wrong     <= cfg_data_i[CountW-1:0];
        CFG_LOCK_SEC:   cfg_q.lock_sec      <= cfg_data_i[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_e'(cfg_index_i))
      CFG_TOKEN_LOW, CFG_TOKEN_HIGH, CFG_TOKEN_LEN: state_clr = cfg_we;
      default:                                      state_clr = 1'b0;
    endcase
  end

  // Input register: the held item is processed once the result register
  // is free or is being emptied in the same cycle.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind     <= kind_e'(kind_i);
      item_q.present  <= attempt_present_i;
      item_q.length   <= attempt_length_i;
      item_q.overlong <= attempt_overlong_i;
      item_q.bytes    <= {attempt_bytes_high_i, attempt_bytes_low_i};
    end
  end

  tcl_match u_match (
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .match_o (match)
  );

  tcl_guard u_guard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .match_i     (match),
    .cfg_i       (cfg_q),
    .state_clr_i (state_clr),
    .result_o    (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign granted_o        = res_q.granted;
  assign locked_o         = res_q.locked;
  assign remaining_lock_o = res_q.remaining;
  assign failure_count_o  = res_q.failures;
  assign token_required_o = res_q.token_required;

endmodule

`default_nettype wire

>>> rtl/tcl_match.sv
// ----------------------------------------------------------------------------
// tcl_match
// Compares a presented token with the configured token, byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_match import tcl_pkg::*; (
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  match_o
);

  logic [LenW-1:0] exp_len;
  logic            bytes_ok;
  logic            len_ok;

  // A configured length above the capacity compares as a full-length token.
  assign exp_len = (cfg_i.token_len > TokenBytesLen) ? TokenBytesLen : cfg_i.token_len;

  always_comb begin
    bytes_ok = 1'b1;
    for (int i = 0; i < TokenBytes; i++) begin
      if ((LenW'(i) < exp_len) &&
          (cfg_i.token[i*8 +: 8] != item_i.bytes[i*8 +: 8])) begin
        bytes_ok = 1'b0;
      end
    end
  end

  assign len_ok  = (item_i.length <= TokenBytesLen) && (item_i.length == exp_len);
  assign match_o = item_i.present && !item_i.overlong && len_ok && bytes_ok;

endmodule

`default_nettype wire

>>> rtl/tcl_guard.sv
// ----------------------------------------------------------------------------
// tcl_guard
// Failure counter and lock timer, updated once per item, with result build.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_guard import tcl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  logic    match_i,
  input  cfg_t    cfg_i,
  input  logic    state_clr_i,
  output result_t result_o
);

  logic [CountW-1:0] wrong_q, wrong_d;
  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  logic [CountW-1:0] eff_max;
  logic              locked_now;
  logic              locked_next;
  logic              granted;

  assign eff_max    = (cfg_i.max_wrong == '0) ? CountW'(1) : cfg_i.max_wrong;
  assign locked_now = (wrong_q >= eff_max) && (elapsed_q < cfg_i.lock_sec);

  always_comb begin
    wrong_d   = wrong_q;
    elapsed_d = elapsed_q;
    granted   = 1'b0;
    case (item_i.kind)
      KIND_TICK: begin
        if (elapsed_q != TimeMax) begin
          elapsed_d = elapsed_q + TimeW'(1);
        end
      end
      KIND_ATTEMPT: begin
        if (!locked_now) begin
          if (cfg_i.token_len == '0) begin
            granted = 1'b1;
          end else if (match_i) begin
            granted = 1'b1;
            wrong_d = '0;
          end else begin
            if (wrong_q < eff_max) begin
              wrong_d = wrong_q + CountW'(1);
            end
            // Reaching the maximum restarts the lock timer.
            if (wrong_d >= eff_max) begin
              elapsed_d = '0;
            end
          end
        end
      end
      KIND_CLEAR: begin
        wrong_d   = '0;
        elapsed_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign locked_next = (wrong_d >= eff_max) && (elapsed_d < cfg_i.lock_sec);

  always_comb begin
    result_o.granted        = granted;
    result_o.locked         = locked_next;
    result_o.remaining      = locked_next ? (cfg_i.lock_sec - elapsed_d) : '0;
    result_o.failures       = wrong_d;
    result_o.token_required = (cfg_i.token_len != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrong_q   <= '0;
      elapsed_q <= '0;
    end else if (state_clr_i) begin
      wrong_q   <= '0;
      elapsed_q <= '0;
    end else if (fire_i) begin
      wrong_q   <= wrong_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire
